>>> sv/slt_pkg.sv
package slt_pkg;

    // result kinds
    localparam logic [1:0] KIND_CHAR      = 2'd0;
    localparam logic [1:0] KIND_END_TOKEN = 2'd1;
    localparam logic [1:0] KIND_END_LINE  = 2'd2;

    // quote modes
    localparam logic [1:0] QUOTE_NONE   = 2'd0;
    localparam logic [1:0] QUOTE_SINGLE = 2'd1;
    localparam logic [1:0] QUOTE_DOUBLE = 2'd2;

    // special characters
    localparam logic [6:0] CH_NUL    = 7'h00;
    localparam logic [6:0] CH_SPACE  = 7'h20;
    localparam logic [6:0] CH_DQUOTE = 7'h22;
    localparam logic [6:0] CH_SQUOTE = 7'h27;
    localparam logic [6:0] CH_LT     = 7'h3C;
    localparam logic [6:0] CH_GT     = 7'h3E;
    localparam logic [6:0] CH_BAR    = 7'h7C;

    // most results one item can cause
    localparam int MAX_RESULTS = 4;

    typedef struct packed {
        logic [6:0] ch;
        logic       has_char;
        logic       end_of_line;
    } t_chr_item;

    typedef struct packed {
        logic [1:0] kind;
        logic [6:0] char_out;
        logic       last_of_run;
    } t_tok_item;

    function automatic logic is_operator(input logic [6:0] c);
        return (c == CH_LT) || (c == CH_GT) || (c == CH_BAR);
    endfunction

endpackage

>>> sv/slt_stream_if.sv
interface slt_stream_if #(parameter type T = logic);
    logic valid;
    logic ready;
    T     data;

    modport source (output valid, output data, input ready);
    modport sink (input valid, input data, output ready);
endinterface

>>> sv/shell_line_tokenizer.sv
// Streaming command-line tokenizer. One character item is taken per cycle while ready is
// high; its results (token characters, end-of-token markers, end-of-line marker; at most
// four) are computed in the same cycle into a four-entry result buffer and leave one per
// cycle while the output is ready, the last one flagged by last_of_run. The next character is
// taken as soon as the buffer holds at most one result that is being taken in that cycle, so
// items that cause one result or none run at one per cycle while the output is ready; an
// item that causes more results holds the input until all but its last have left the port.
module shell_line_tokenizer
    import slt_pkg::*;
(
    input  logic         i_clk,
    input  logic         i_rst_n,
    slt_stream_if.sink   i_chr,
    slt_stream_if.source o_tok
);

    localparam int CNT_W = $clog2(MAX_RESULTS + 1);

    // tokenizer state
    logic       r_it, n_it;
    logic [1:0] r_qm, n_qm;
    logic [6:0] r_po, n_po;

    // result buffer, head at entry 0
    t_tok_item        r_buf [MAX_RESULTS];
    logic [CNT_W-1:0] r_cnt;

    t_tok_item        res [MAX_RESULTS];
    logic [CNT_W-1:0] cnt;

    logic in_fire;
    logic out_fire;

    // handshake
    assign o_tok.valid = (r_cnt != '0);
    assign o_tok.data  = r_buf[0];
    assign out_fire    = o_tok.valid && o_tok.ready;
    assign i_chr.ready = (r_cnt == '0) || ((r_cnt == CNT_W'(1)) && o_tok.ready);
    assign in_fire     = i_chr.valid && i_chr.ready;

    // results and next state for the offered item
    always_comb begin
        logic [6:0] c;
        logic       take;
        logic       done;
        c    = i_chr.data.ch;
        take = i_chr.data.has_char && (c != CH_NUL);
        done = 1'b0;
        n_it = r_it;
        n_qm = r_qm;
        n_po = r_po;
        cnt  = '0;
        for (int k = 0; k < MAX_RESULTS; k++) begin
            res[k] = '0;
        end

        if (take) begin
            // resolve a held operator
            if (r_po != CH_NUL) begin
                if (c == r_po) begin
                    res[cnt[1:0]] = '{KIND_CHAR, c, 1'b0};
                    cnt = cnt + 1'b1;
                    res[cnt[1:0]] = '{KIND_END_TOKEN, 7'd0, 1'b0};
                    cnt = cnt + 1'b1;
                    done = 1'b1;
                end else begin
                    res[cnt[1:0]] = '{KIND_END_TOKEN, 7'd0, 1'b0};
                    cnt = cnt + 1'b1;
                end
                n_po = CH_NUL;
                n_it = 1'b0;
            end
            if (!done) begin
                if (n_qm != QUOTE_NONE) begin
                    // quoted text
                    res[cnt[1:0]] = '{KIND_CHAR, c, 1'b0};
                    cnt = cnt + 1'b1;
                    n_it = 1'b1;
                    if (((n_qm == QUOTE_SINGLE) && (c == CH_SQUOTE)) ||
                        ((n_qm == QUOTE_DOUBLE) && (c == CH_DQUOTE))) begin
                        n_qm = QUOTE_NONE;
                    end
                end else if (c == CH_SPACE) begin
                    if (n_it) begin
                        res[cnt[1:0]] = '{KIND_END_TOKEN, 7'd0, 1'b0};
                        cnt = cnt + 1'b1;
                        n_it = 1'b0;
                    end
                end else if (is_operator(c)) begin
                    if (n_it) begin
                        res[cnt[1:0]] = '{KIND_END_TOKEN, 7'd0, 1'b0};
                        cnt = cnt + 1'b1;
                    end
                    res[cnt[1:0]] = '{KIND_CHAR, c, 1'b0};
                    cnt = cnt + 1'b1;
                    n_po = c;
                    n_it = 1'b1;
                end else begin
                    if (c == CH_SQUOTE) begin
                        n_qm = QUOTE_SINGLE;
                    end else if (c == CH_DQUOTE) begin
                        n_qm = QUOTE_DOUBLE;
                    end
                    res[cnt[1:0]] = '{KIND_CHAR, c, 1'b0};
                    cnt = cnt + 1'b1;
                    n_it = 1'b1;
                end
            end
        end

        // end of line closes the open token
        if (i_chr.data.end_of_line) begin
            if (n_it || (n_po != CH_NUL)) begin
                res[cnt[1:0]] = '{KIND_END_TOKEN, 7'd0, 1'b0};
                cnt = cnt + 1'b1;
            end
            res[cnt[1:0]] = '{KIND_END_LINE, 7'd0, 1'b0};
            cnt = cnt + 1'b1;
            n_it = 1'b0;
            n_qm = QUOTE_NONE;
            n_po = CH_NUL;
        end

        // flag the last result
        if (cnt != '0) begin
            res[2'(cnt - 1'b1)].last_of_run = 1'b1;
        end
    end

    // control state
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_it  <= 1'b0;
            r_qm  <= QUOTE_NONE;
            r_po  <= CH_NUL;
            r_cnt <= '0;
        end else if (in_fire) begin
            r_it  <= n_it;
            r_qm  <= n_qm;
            r_po  <= n_po;
            r_cnt <= cnt;
        end else if (out_fire) begin
            r_cnt <= r_cnt - 1'b1;
        end
    end

    // result buffer: load on accept, shift on pop
    always_ff @(posedge i_clk) begin
        if (in_fire) begin
            r_buf <= res;
        end else if (out_fire) begin
            for (int k = 0; k < MAX_RESULTS - 1; k++) begin
                r_buf[k] <= r_buf[k + 1];
            end
        end
    end

    // checks
    a_cnt_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_cnt <= CNT_W'(MAX_RESULTS))
        else $error("result count out of range");

    a_op_unquoted: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_po != CH_NUL) |-> ((r_qm == QUOTE_NONE) && r_it))
        else $error("held operator inside quote or outside token");

    a_eol_clears: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (in_fire && i_chr.data.end_of_line) |=>
            (!r_it && (r_qm == QUOTE_NONE) && (r_po == CH_NUL)))
        else $error("state not cleared after end of line");

    a_last_flag: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_tok.valid |-> (o_tok.data.last_of_run == (r_cnt == CNT_W'(1))))
        else $error("last_of_run does not match buffer fill");

endmodule
